@@ rtl/fwcs_pkg.sv @@
// Shared constants, transaction types and slot-map control for the challenge sampler.
package fwcs_pkg;

   localparam int KEY_COUNT     = 4;
   localparam int VECTOR_LEN    = 256;
   localparam int TARGET_WEIGHT = 32;

   localparam int WORD_W   = 16;
   localparam int VBITS    = $clog2(KEY_COUNT);        // bit length of KEY_COUNT-1
   localparam int PBITS    = $clog2(VECTOR_LEN + 1);   // bit length of VECTOR_LEN
   localparam int IDX_W    = $clog2(VECTOR_LEN);
   localparam int POS_W    = 8;
   localparam int SVAL_W   = 2;
   localparam int COUNT_W  = 9;

   localparam logic CMD_CLEAR = 1'b0;
   localparam logic CMD_OFFER = 1'b1;

   typedef struct packed {
      logic              command;
      logic [WORD_W-1:0] rand_word;
   } fwcs_req_type;

   typedef struct packed {
      logic               accepted;
      logic [POS_W-1:0]   position;
      logic [SVAL_W-1:0]  slot_value;
      logic [COUNT_W-1:0] placed_count;
      logic               done_res;
   } fwcs_rsp_type;

   typedef struct packed {
      logic             clear;
      logic             set;
      logic [IDX_W-1:0] index;
   } fwcs_slot_ctrl_type;

endpackage

@@ rtl/fwcs_occupancy.sv @@
// Occupancy flags of the challenge vector: one flag per slot marks a nonzero entry.
module fwcs_occupancy (
   input  logic                        clock,
   input  logic                        reset,
   input  fwcs_pkg::fwcs_slot_ctrl_type slot_ctrl,
   output logic                        occupied
);
   import fwcs_pkg::*;

   logic [VECTOR_LEN-1:0] flags_ff;
   logic [VECTOR_LEN-1:0] flags_in;

   always_comb begin
      flags_in = flags_ff;
      if (slot_ctrl.clear) begin
         flags_in = '0;
      end else if (slot_ctrl.set) begin
         flags_in[slot_ctrl.index] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
      end else begin
         flags_ff <= flags_in;
      end
   end

   assign occupied = flags_ff[slot_ctrl.index];

`ifndef NO_ASSERTIONS
   a_set_marks_slot: assert property (@(posedge clock) disable iff (reset)
      slot_ctrl.set && !slot_ctrl.clear |=> flags_ff[$past(slot_ctrl.index)])
      else $error("slot flag not raised after placement");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      slot_ctrl.clear |=> flags_ff == '0)
      else $error("slot flags not empty after clear");
`endif

endmodule

@@ rtl/fwcs_eval.sv @@
// Word split, rejection tests, weight counter and result formation.
module fwcs_eval (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         fire,
   input  fwcs_pkg::fwcs_req_type       req,
   input  logic                         occupied,
   output fwcs_pkg::fwcs_slot_ctrl_type slot_ctrl,
   output fwcs_pkg::fwcs_rsp_type       rsp
);
   import fwcs_pkg::*;

   logic [COUNT_W-1:0]              count_ff;
   logic [COUNT_W-1:0]              count_in;
   logic [COUNT_W-1:0]              count_after;
   logic [WORD_W+VBITS+PBITS-1:0]   word_ext;
   logic [VBITS-1:0]                value;
   logic [PBITS-1:0]                pos;
   logic [PBITS+POS_W-1:0]          pos_wide;
   logic [VBITS+SVAL_W-1:0]         value_wide;
   logic                            is_offer;
   logic                            below_target;
   logic                            value_ok;
   logic                            pos_ok;
   logic                            take;
   logic                            nonzero;

   // Zero-extend so that position bits beyond the word read as zero.
   assign word_ext   = {{(VBITS + PBITS){1'b0}}, req.rand_word};
   assign value      = word_ext[VBITS-1:0];
   assign pos        = word_ext[VBITS +: PBITS];
   assign pos_wide   = {{POS_W{1'b0}}, pos};
   assign value_wide = {{SVAL_W{1'b0}}, value};

   assign is_offer     = (req.command == CMD_OFFER);
   assign below_target = (count_ff < COUNT_W'(TARGET_WEIGHT));
   assign value_ok     = ({1'b0, value} < (VBITS + 1)'(KEY_COUNT));
   assign pos_ok       = (pos < PBITS'(VECTOR_LEN));
   assign nonzero      = (value != '0);
   assign take         = is_offer && below_target && value_ok && pos_ok && !occupied;

   assign slot_ctrl.index = pos[IDX_W-1:0];
   assign slot_ctrl.clear = fire && !is_offer;
   assign slot_ctrl.set   = fire && take && nonzero;

   always_comb begin
      if (!is_offer) begin
         count_after = '0;
      end else if (take && nonzero) begin
         count_after = count_ff + 1'b1;
      end else begin
         count_after = count_ff;
      end
      count_in = fire ? count_after : count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_comb begin
      rsp.accepted     = take;
      rsp.position     = take ? pos_wide[POS_W-1:0] : '0;
      rsp.slot_value   = take ? value_wide[SVAL_W-1:0] : '0;
      rsp.placed_count = count_after;
      rsp.done_res     = (count_after >= COUNT_W'(TARGET_WEIGHT));
   end

`ifndef NO_ASSERTIONS
   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(TARGET_WEIGHT))
      else $error("placed count beyond target weight");

   a_clear_zeroes_count: assert property (@(posedge clock) disable iff (reset)
      slot_ctrl.clear |=> count_ff == '0)
      else $error("count not zero after clear");

   a_place_counts_once: assert property (@(posedge clock) disable iff (reset)
      slot_ctrl.set |=> count_ff == COUNT_W'($past(count_ff) + 1'b1))
      else $error("nonzero placement did not advance the count by one");
`endif

endmodule

@@ rtl/fixed_weight_challenge_sampler.sv @@
// Top level of the fixed-weight challenge sampler: input register, evaluation, result register.
//
// Usage
//   Request channel (req_valid / req_stall / req_payload): each transaction carries a command
//   and a 16-bit XOF word. CMD_CLEAR empties the challenge vector and the weight count;
//   CMD_OFFER proposes the word for placement (low bits value, next bits slot).
//   Response channel (rsp_valid / rsp_stall / rsp_payload): exactly one response per request,
//   in order, giving whether the word was placed, the slot and value, the running count of
//   nonzero entries and whether the target weight has been reached.
//   A request passes from the input register to the result register; throughput is one
//   transaction per cycle while rsp_stall is low. The slot lookup and the flag
//   update happen in the single evaluation step between the two registers, so a word always
//   sees every earlier placement without forwarding.
//   Reset clears the vector, the count and both pipeline stages directly; no sweep.
//   When rsp_stall is held, the pending response holds and one more request is still
//   taken into the input register if it is empty; only then does req_stall rise.
module fixed_weight_challenge_sampler (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  fwcs_pkg::fwcs_req_type req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output fwcs_pkg::fwcs_rsp_type rsp_payload
);
   import fwcs_pkg::*;

   logic               s1_valid_ff;
   logic               s1_valid_in;
   fwcs_req_type       s1_req_ff;
   logic               out_valid_ff;
   logic               out_valid_in;
   fwcs_rsp_type       out_rsp_ff;
   logic               out_ready;
   logic               s1_move;
   logic               req_fire;
   logic               occupied;
   fwcs_slot_ctrl_type slot_ctrl;
   fwcs_rsp_type       eval_rsp;

   // The result register can take a new value when empty or being drained.
   assign out_ready = !out_valid_ff || !rsp_stall;
   assign s1_move   = s1_valid_ff && out_ready;
   // Hold the requester off only when the input register is full and cannot move on.
   assign req_stall = s1_valid_ff && !out_ready;
   assign req_fire  = req_valid && !req_stall;

   assign s1_valid_in  = req_stall ? s1_valid_ff : req_valid;
   assign out_valid_in = out_ready ? s1_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers: capture only on transfer, no reset needed.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_req_ff <= req_payload;
      end
      if (s1_move) begin
         out_rsp_ff <= eval_rsp;
      end
   end

   // Evaluate the held word; state updates only when the result advances.
   fwcs_eval u_eval (
      .clock     (clock),
      .reset     (reset),
      .fire      (s1_move),
      .req       (s1_req_ff),
      .occupied  (occupied),
      .slot_ctrl (slot_ctrl),
      .rsp       (eval_rsp)
   );

   fwcs_occupancy u_occupancy (
      .clock     (clock),
      .reset     (reset),
      .slot_ctrl (slot_ctrl),
      .occupied  (occupied)
   );

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_rsp_ff;

`ifndef NO_ASSERTIONS
   a_no_state_change_when_blocked: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && out_valid_ff && rsp_stall |-> !slot_ctrl.set && !slot_ctrl.clear)
      else $error("vector state changed while the result register was blocked");
`endif

endmodule
